[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/skst_pkg.sv]
`default_nettype none

package skst_pkg;

  // command codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_PRIVATE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;

  typedef struct packed {
    logic        command;
    logic [7:0]  mount_number;
    logic [63:0] inode_number;
    logic [7:0]  release_slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot;
  } rsp_t;

  // one slot as stored in the table memory
  typedef struct packed {
    logic        valid;
    logic [7:0]  mount;
    logic [63:0] inode;
  } entry_t;

endpackage

`default_nettype wire

[rtl/shared_key_slot_table_top.sv]
// shared key slot table: lookup-or-insert of (mount, inode) keys in a slot memory
//
// request channel (req_valid/req_ready/req) carries one beat per command:
//   acquire looks up the key, returning the matching slot (hit) or claiming the
//   lowest free slot (inserted); inode zero answers private, no free slot full.
//   release frees the named slot and echoes it back.
// response channel (rsp_valid/rsp_ready/rsp) returns exactly one beat per request.
//
// release and private acquire skip the scan; a hit ends the scan at its slot.
// the acquire time is set by the scan through the slot memory, one read per cycle
// on its single read port, plus the registered read and, for an insert, a write.
// one command in flight, req_ready high only while idle.
// reset: a clearing pass writes every slot free, with req_ready low until done.
// stall: the response sits in an output register while rsp_ready is low; the
// next command can be accepted and worked on meanwhile, and its result waits
// in the scan unit until the output register frees up.
`default_nettype none

module shared_key_slot_table_top #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire skst_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output skst_pkg::rsp_t       rsp
);

  import skst_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int EW = $bits(entry_t);

  // scan unit to output register
  logic     res_valid;
  logic     res_ready;
  rsp_t     res;

  // slot memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic [EW-1:0] rd_bits;

  assign rd_data = rd_bits;

  skst_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_bits)
  );

  skst_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // output register, refilled as soon as the current beat leaves
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/skst_ram.sv]
`default_nettype none

module skst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/skst_scan.sv]
`default_nettype none

module skst_scan #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire skst_pkg::req_t                   req,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output skst_pkg::rsp_t                        res,
  output logic                                  wr_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      wr_addr,
  output skst_pkg::entry_t                      wr_data,
  output logic                                  rd_en,
  output logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr,
  input  wire skst_pkg::entry_t                 rd_data
);

  import skst_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   scan_addr;
  logic [AW-1:0]   cmp_idx;
  logic [AW-1:0]   free_idx;
  logic            issuing;
  logic            cmp_pend;
  logic            have_free;
  logic [7:0]      key_mount;
  logic [63:0]     key_inode;

  logic entry_hit;
  logic entry_free;
  logic last_cmp;
  logic rel_in_range;

  assign entry_hit    = rd_data.valid && (rd_data.mount == key_mount)
                        && (rd_data.inode == key_inode);
  assign entry_free   = !rd_data.valid;
  assign last_cmp     = (cmp_idx == LAST);
  assign rel_in_range = (32'(req.release_slot) < 32'(TABLE_ENTRIES));

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign rd_en     = (state == S_SCAN) && issuing;
  assign rd_addr   = scan_addr;

  // single write port: clearing pass, release, insert
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        wr_en   = req_valid && (req.command == CMD_RELEASE) && rel_in_range;
        wr_addr = AW'(req.release_slot);
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = free_idx;
        wr_data = '{valid: 1'b1, mount: key_mount, inode: key_inode};
      end
      S_SCAN, S_FINISH: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      issuing   <= 1'b0;
      cmp_pend  <= 1'b0;
      have_free <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            key_mount <= req.mount_number;
            key_inode <= req.inode_number;
            if (req.command == CMD_RELEASE) begin
              res   <= '{status: ST_RELEASED, slot: req.release_slot};
              state <= S_FINISH;
            end else if (req.inode_number == 64'd0) begin
              res   <= '{status: ST_PRIVATE, slot: 8'd0};
              state <= S_FINISH;
            end else begin
              scan_addr <= '0;
              issuing   <= 1'b1;
              cmp_pend  <= 1'b0;
              have_free <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_pend <= issuing;
          cmp_idx  <= scan_addr;
          if (issuing) begin
            if (scan_addr == LAST) begin
              issuing <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (cmp_pend) begin
            if (entry_hit) begin
              res     <= '{status: ST_HIT, slot: 8'(cmp_idx)};
              issuing <= 1'b0;
              state   <= S_FINISH;
            end else begin
              if (entry_free && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= cmp_idx;
              end
              if (last_cmp) begin
                if (have_free || entry_free) begin
                  state <= S_WRITE;
                end else begin
                  res   <= '{status: ST_FULL, slot: 8'd0};
                  state <= S_FINISH;
                end
              end
            end
          end
        end
        S_WRITE: begin
          res   <= '{status: ST_INSERTED, slot: 8'(free_idx)};
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/skst_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module skst_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_ready,
  input wire skst_pkg::req_t  req,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire skst_pkg::rsp_t  rsp
);

  import skst_pkg::*;

  logic req_seen;
  logic rsp_stall;
  logic rsp_slotless;
  assign req_seen = req_valid && (req.command == CMD_RELEASE || req.command == CMD_ACQUIRE);
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_slotless = rsp_valid && (rsp.status == ST_PRIVATE || rsp.status == ST_FULL);

  // stalled response beat holds
  `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")

  // one command at a time
  `ASSERT_NEXT(a_one_in_flight, req_seen && req_ready, !req_ready, "req_ready high after accept")

  // only defined status codes
  `ASSERT_SAME(a_status_code, rsp_valid, rsp.status <= ST_RELEASED, "undefined status code")

  // private and full answers carry no slot
  `ASSERT_SAME(a_no_slot, rsp_slotless, rsp.slot == 8'd0, "slot not zero on private or full")

endmodule

bind shared_key_slot_table_top skst_checker u_checker (.*);

`default_nettype wire

[tb/shared_key_slot_table_top_tb.sv]
`default_nettype none

module shared_key_slot_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skst_pkg::*;

  localparam int TABLE_ENTRIES = 256;
  // longest stretch with no beat on either side: reset plus the clearing pass,
  // or a full miss scan while the response side stalls, with a wide margin
  localparam int IDLE_LIMIT = 4000;
  // slowest command is a miss: full scan plus read and write cycles
  localparam int TAIL_CYCLES = TABLE_ENTRIES + 40;
  localparam int RANDOM_ROUNDS = 25;
  localparam int ROUND_BEATS = 52;
  localparam int IDLE_PCT = 22;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  shared_key_slot_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow copy of the slot table, updated as each request beat is taken
  logic live[TABLE_ENTRIES];
  logic [7:0] held_mount[TABLE_ENTRIES];
  logic [63:0] held_inode[TABLE_ENTRIES];

  rsp_t awaited_rsp[$];
  int errors = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;
  int status_seen[8];
  // when set, neither side inserts idle cycles
  logic steady = 1'b0;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      live[i] = 1'b0;
      held_mount[i] = '0;
      held_inode[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
  end

  // answer of the table to one command, applying its effect on the slots
  function automatic rsp_t lookup_or_insert(input req_t r);
    rsp_t o;
    int free_at;
    free_at = -1;
    o.status = ST_RELEASED;
    o.slot = r.release_slot;
    // release frees the named slot whatever its state, key fields unused
    if (r.command == CMD_RELEASE) begin
      if (int'(r.release_slot) < TABLE_ENTRIES) live[r.release_slot] = 1'b0;
      return o;
    end
    o.slot = '0;
    // inode zero is never shared: no search, no change
    if (r.inode_number == '0) begin
      o.status = ST_PRIVATE;
      return o;
    end
    // a match anywhere wins over a lower free slot
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (live[i]) begin
        if (held_mount[i] == r.mount_number && held_inode[i] == r.inode_number) begin
          o.status = ST_HIT;
          o.slot = 8'(i);
          return o;
        end
      end else if (free_at < 0) begin
        free_at = i;
      end
    end
    if (free_at < 0) begin
      o.status = ST_FULL;
      return o;
    end
    live[free_at] = 1'b1;
    held_mount[free_at] = r.mount_number;
    held_inode[free_at] = r.inode_number;
    o.status = ST_INSERTED;
    o.slot = 8'(free_at);
    return o;
  endfunction

  // acquire beat; release_slot is ignored by the block, so it gets noise
  function automatic req_t acquire_req(input logic [7:0] m, input logic [63:0] n);
    req_t r;
    r.command = CMD_ACQUIRE;
    r.mount_number = m;
    r.inode_number = n;
    r.release_slot = 8'($urandom);
    return r;
  endfunction

  // release beat; key fields are ignored by the block, so they get noise
  function automatic req_t release_req(input logic [7:0] s);
    req_t r;
    r.command = CMD_RELEASE;
    r.mount_number = 8'($urandom);
    r.inode_number = {$urandom, $urandom};
    r.release_slot = s;
    return r;
  endfunction

  // random occupied slot, or -1 when the table is empty
  function automatic int pick_live_slot();
    int start;
    start = $urandom_range(TABLE_ENTRIES - 1);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (live[(start + k) % TABLE_ENTRIES]) return (start + k) % TABLE_ENTRIES;
    return -1;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    // keep the log short if the stream falls out of step
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  // drive one request beat, hold it until taken, then maybe idle a while
  task automatic send_beat(input req_t r);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    awaited_rsp.push_back(lookup_or_insert(r));
    beats_sent++;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < IDLE_PCT);
    end
  endtask

  // sender holds off until every answer is back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  // response side backpressure
  always @(posedge clk) rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

  // compare each response beat with the oldest prediction
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("response with nothing pending: status %0d slot %0d",
                                  rsp.status, rsp.slot));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d (slot %0d)",
                                    rsp.status, want.status, want.slot));
        if (rsp.slot !== want.slot)
          report_mismatch($sformatf("slot %0d, predicted %0d (status %0d)",
                                    rsp.slot, want.slot, want.status));
        status_seen[want.status]++;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // inode zero, with both mount extremes
  task automatic test_private_key();
    send_beat(acquire_req(8'hFF, 64'd0));
    send_beat(acquire_req(8'h00, 64'd0));
  endtask

  // first inserts and hits, key fields at their extremes, single-bit differences
  task automatic test_insert_and_hit();
    send_beat(acquire_req(8'h00, 64'd1));
    send_beat(acquire_req(8'h00, 64'd1));
    send_beat(acquire_req(8'hFF, '1));
    send_beat(acquire_req(8'hFF, '1));
    send_beat(acquire_req(8'hFE, '1));
    send_beat(acquire_req(8'hFF, 64'h7FFF_FFFF_FFFF_FFFF));
    send_beat(acquire_req(8'h00, 64'h8000_0000_0000_0000));
  endtask

  // a match above a freed lower slot must hit, not insert
  task automatic test_hit_before_insert();
    send_beat(release_req(8'd0));
    send_beat(acquire_req(8'hFF, '1));
    send_beat(acquire_req(8'h00, 64'd1));
    send_beat(release_req(8'd2));
    send_beat(acquire_req(8'h00, 64'h8000_0000_0000_0000));
  endtask

  // releases of free and occupied slots, top slot, repeated release
  task automatic test_release();
    send_beat(release_req(8'd255));
    send_beat(release_req(8'd200));
    send_beat(release_req(8'd200));
    send_beat(release_req(8'd1));
    send_beat(acquire_req(8'h5A, 64'h0123_4567_89AB_CDEF));
    send_beat(acquire_req(8'hFF, '1));
    wait_for_drain();
  endtask

  // fill every slot, then full answers, a hit at the top slot and refills
  task automatic test_table_full();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!live[i]) send_beat(acquire_req(8'(i), {32'hC0DE_0000, 32'(i)}));
    send_beat(acquire_req(8'hA5, 64'hDEAD_BEEF_0000_0001));
    send_beat(acquire_req(held_mount[TABLE_ENTRIES - 1], held_inode[TABLE_ENTRIES - 1]));
    send_beat(acquire_req(8'h33, 64'd0));
    send_beat(release_req(8'd17));
    send_beat(release_req(8'd200));
    send_beat(acquire_req(8'hA5, 64'hDEAD_BEEF_0000_0001));
    send_beat(acquire_req(8'hA5, 64'hDEAD_BEEF_0000_0002));
    send_beat(acquire_req(8'hA5, 64'hDEAD_BEEF_0000_0003));
    wait_for_drain();
  endtask

  // acquire mostly aimed at stored keys or near misses, with a small key
  // space so freed keys come back, plus private keys and wide noise
  task automatic random_acquire();
    int s;
    int pick;
    logic [7:0] m;
    logic [63:0] n;
    s = pick_live_slot();
    pick = $urandom_range(99);
    m = 8'($urandom);
    n = {$urandom, $urandom};
    if (s >= 0 && pick < 40) begin
      m = held_mount[s];
      n = held_inode[s];
    end else if (s >= 0 && pick < 50) begin
      m = held_mount[s];
      n = held_inode[s] ^ (64'd1 << $urandom_range(63));
    end else if (s >= 0 && pick < 57) begin
      m = held_mount[s] ^ (8'd1 << $urandom_range(7));
      n = held_inode[s];
    end else if (pick < 63) begin
      n = '0;
    end else if (pick < 85) begin
      m = 8'($urandom_range(3));
      n = 64'($urandom_range(40, 1));
    end
    send_beat(acquire_req(m, n));
  endtask

  // rounds with varying release rate so occupancy swings from empty to full
  task automatic test_random_traffic();
    int release_pct;
    int s;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case ($urandom_range(3))
        0: release_pct = 8;
        1: release_pct = 25;
        2: release_pct = 45;
        default: release_pct = 70;
      endcase
      // one round runs with no idling on either side
      steady = (round == 3);
      for (int k = 0; k < ROUND_BEATS; k++) begin
        if ($urandom_range(99) < release_pct) begin
          s = pick_live_slot();
          if (s < 0 || $urandom_range(99) < 25) s = $urandom_range(TABLE_ENTRIES - 1);
          send_beat(release_req(8'(s)));
        end else begin
          random_acquire();
        end
      end
      if (round % 5 == 4) wait_for_drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_private_key();
    test_insert_and_hit();
    test_hit_before_insert();
    test_release();
    test_table_full();
    test_random_traffic();

    // all stimulus in, wait for the last answers then a quiet tail
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d request beats: %0d hits, %0d inserts, %0d private keys,",
             beats_sent, status_seen[ST_HIT], status_seen[ST_INSERTED],
             status_seen[ST_PRIVATE]);
    $display("  %0d table-full answers, %0d releases; %0d mismatches",
             status_seen[ST_FULL], status_seen[ST_RELEASED], errors);
    if (errors == 0 && awaited_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
